// ----- src/rau_pkg.sv -----
// shared types and codes for the rational arithmetic unit
// used by rau_ctrl, rau_dp and rational_arith_unit_top; no dependencies
package rau_pkg;

	localparam int unsigned WORD_BITS_DEF = 32;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZDEN = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// multiplier steps: first num term, second cross term, den term
	localparam logic [1:0] MS_T1 = 2'd0;
	localparam logic [1:0] MS_T2 = 2'd1;
	localparam logic [1:0] MS_T3 = 2'd2;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mul_step;
		logic       comb;
		logic       gcd_step;
		logic       div_init;
		logic       div_den;
		logic       div_step;
		logic       store_num;
		logic       store_den;
		logic       out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic err;
		logic gcd_done;
		logic div_done;
	} rau_stat_t;

endpackage

// ----- src/rau_ctrl.sv -----
// sequencer for the rational arithmetic unit
// drives rau_dp commands from its status; uses rau_pkg
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rau_pkg::rau_stat_t stat,
	output rau_pkg::rau_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MUL0 = 4'd1;
	localparam logic [3:0] S_MUL1 = 4'd2;
	localparam logic [3:0] S_MUL2 = 4'd3;
	localparam logic [3:0] S_COMB = 4'd4;
	localparam logic [3:0] S_GCD  = 4'd5;
	localparam logic [3:0] S_DIVN = 4'd6;
	localparam logic [3:0] S_DIVD = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL0;
				end
			end
			S_MUL0: begin
				if (stat.err) begin
					state_d = S_FIN;
				end else begin
					cmd.mul_en   = 1'b1;
					cmd.mul_step = rau_pkg::MS_T1;
					state_d      = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = rau_pkg::MS_T2;
				state_d      = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_step = rau_pkg::MS_T3;
				state_d      = S_COMB;
			end
			S_COMB: begin
				cmd.comb = 1'b1;
				state_d  = S_GCD;
			end
			S_GCD: begin
				if (stat.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = S_DIVN;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			S_DIVN: begin
				// numerator quotient ready, start on the denominator
				if (stat.div_done) begin
					cmd.store_num = 1'b1;
					cmd.div_init  = 1'b1;
					cmd.div_den   = 1'b1;
					state_d       = S_DIVD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_DIVD: begin
				if (stat.div_done) begin
					cmd.store_den = 1'b1;
					state_d       = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			priority if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end else begin
				ov_q <= ov_q;
			end
		end
	end

endmodule

// ----- src/rau_dp.sv -----
// datapath: operand capture, shared multiplier, signed combine, binary gcd,
// restoring divider and output register; uses rau_pkg
module rau_dp #(
	parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic                clk,
	input  rau_pkg::rau_cmd_t   cmd,
	output rau_pkg::rau_stat_t  stat,
	input  logic [1:0]          req_type,
	input  logic signed [31:0]  a_num,
	input  logic signed [31:0]  a_den,
	input  logic signed [31:0]  b_num,
	input  logic signed [31:0]  b_den,
	output logic signed [31:0]  res_num,
	output logic [30:0]         res_den,
	output logic [1:0]          status,
	output logic                is_zero,
	output logic                is_one
);

	localparam int unsigned W  = WORD_BITS;
	localparam int unsigned PW = 2 * WORD_BITS;
	localparam int unsigned KW = $clog2(PW);
	localparam int unsigned CW = $clog2(PW + 1);
	localparam logic [PW-1:0] LIM_NEG = PW'(1) << (WORD_BITS - 1);
	localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

	// operand slots: 0 a_num, 1 a_den, 2 b_num, 3 b_den
	logic [1:0]    op_q;
	logic          err_q;
	logic          opn_neg_q [4];
	logic [W-1:0]  opn_mag_q [4];

	logic [PW-1:0] prod_q [3];
	logic          prod_neg_q [3];

	logic [PW-1:0] num_q;
	logic [PW-1:0] den_q;
	logic          neg_q;

	logic [PW-1:0] ga_q;
	logic [PW-1:0] gb_q;
	logic [KW-1:0] k_q;

	logic [PW-1:0] dg_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] quo_q;
	logic [CW-1:0] dcnt_q;

	function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
		logic [W-1:0] n;
		n = ~v + 1'b1;
		return v[W-1] ? n : v;
	endfunction

	// shared multiplier
	logic [W-1:0]  mul_x;
	logic [W-1:0]  mul_y;
	logic          mul_s;
	logic [PW-1:0] mul_p;

	always_comb begin
		unique case (cmd.mul_step)
			rau_pkg::MS_T1: begin
				mul_x = opn_mag_q[0];
				mul_y = (op_q == rau_pkg::OP_MUL) ? opn_mag_q[2] : opn_mag_q[3];
				mul_s = opn_neg_q[0] ^
					((op_q == rau_pkg::OP_MUL) ? opn_neg_q[2] : opn_neg_q[3]);
			end
			rau_pkg::MS_T2: begin
				mul_x = opn_mag_q[1];
				mul_y = opn_mag_q[2];
				mul_s = opn_neg_q[1] ^ opn_neg_q[2];
			end
			default: begin
				mul_x = opn_mag_q[1];
				mul_y = opn_mag_q[3];
				mul_s = opn_neg_q[1] ^ opn_neg_q[3];
			end
		endcase
	end

	assign mul_p = PW'(mul_x) * PW'(mul_y);

	// signed combine of the products
	logic          t2_s;
	logic          t_ge;
	logic [PW-1:0] add_mag;
	logic          add_neg;
	logic [PW-1:0] c_num;
	logic          c_num_s;
	logic [PW-1:0] c_den;
	logic          c_den_s;
	logic          c_neg;

	always_comb begin
		t2_s = prod_neg_q[1] ^ (op_q == rau_pkg::OP_SUB);
		t_ge = (prod_q[0] >= prod_q[1]);
		priority if (prod_neg_q[0] == t2_s) begin
			add_mag = prod_q[0] + prod_q[1];
			add_neg = prod_neg_q[0];
		end else if (t_ge) begin
			add_mag = prod_q[0] - prod_q[1];
			add_neg = prod_neg_q[0];
		end else begin
			add_mag = prod_q[1] - prod_q[0];
			add_neg = t2_s;
		end
		unique case (op_q)
			rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
				c_num   = add_mag;
				c_num_s = add_neg;
				c_den   = prod_q[2];
				c_den_s = prod_neg_q[2];
			end
			rau_pkg::OP_MUL: begin
				c_num   = prod_q[0];
				c_num_s = prod_neg_q[0];
				c_den   = prod_q[2];
				c_den_s = prod_neg_q[2];
			end
			default: begin
				c_num   = prod_q[0];
				c_num_s = prod_neg_q[0];
				c_den   = prod_q[1];
				c_den_s = prod_neg_q[1];
			end
		endcase
		c_neg = (c_num != '0) && (c_num_s != c_den_s);
	end

	// gcd result once one side has reached zero
	logic [PW-1:0] g_full;
	assign g_full = (ga_q | gb_q) << k_q;

	// one restoring division step
	logic [PW:0] d_shift;
	logic [PW:0] d_trial;
	logic        d_ge;
	assign d_shift = {rem_q, quo_q[PW-1]};
	assign d_trial = d_shift - {1'b0, dg_q};
	assign d_ge    = (d_shift >= {1'b0, dg_q});

	assign stat.err      = err_q;
	assign stat.gcd_done = (ga_q == '0) || (gb_q == '0);
	assign stat.div_done = (dcnt_q == CW'(PW));

	// output formatting
	logic                ovf;
	logic [W-1:0]        num_w;
	logic signed [W-1:0] num_sw;
	assign ovf    = (den_q > LIM_POS) || (num_q > (neg_q ? LIM_NEG : LIM_POS));
	assign num_w  = neg_q ? (~num_q[W-1:0] + 1'b1) : num_q[W-1:0];
	assign num_sw = signed'(num_w);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= req_type;
			opn_neg_q[0] <= a_num[W-1];
			opn_neg_q[1] <= a_den[W-1];
			opn_neg_q[2] <= b_num[W-1];
			opn_neg_q[3] <= b_den[W-1];
			opn_mag_q[0] <= mag_of(a_num[W-1:0]);
			opn_mag_q[1] <= mag_of(a_den[W-1:0]);
			opn_mag_q[2] <= mag_of(b_num[W-1:0]);
			opn_mag_q[3] <= mag_of(b_den[W-1:0]);
			err_q        <= (a_den[W-1:0] == '0) || (b_den[W-1:0] == '0) ||
				((req_type == rau_pkg::OP_DIV) && (b_num[W-1:0] == '0));
		end

		if (cmd.mul_en) begin
			unique case (cmd.mul_step)
				rau_pkg::MS_T1: begin
					prod_q[0]     <= mul_p;
					prod_neg_q[0] <= mul_s;
				end
				rau_pkg::MS_T2: begin
					prod_q[1]     <= mul_p;
					prod_neg_q[1] <= mul_s;
				end
				default: begin
					prod_q[2]     <= mul_p;
					prod_neg_q[2] <= mul_s;
				end
			endcase
		end

		if (cmd.comb) begin
			num_q <= c_num;
			den_q <= c_den;
			neg_q <= c_neg;
			ga_q  <= c_den;
			gb_q  <= c_num;
			k_q   <= '0;
		end else if (cmd.gcd_step) begin
			// binary gcd: strip common twos, then shift or subtract
			priority if (!ga_q[0] && !gb_q[0]) begin
				ga_q <= ga_q >> 1;
				gb_q <= gb_q >> 1;
				k_q  <= k_q + KW'(1);
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q >= gb_q) begin
				ga_q <= ga_q - gb_q;
			end else begin
				gb_q <= gb_q - ga_q;
			end
		end

		if (cmd.store_num) begin
			num_q <= quo_q;
		end
		if (cmd.store_den) begin
			den_q <= quo_q;
		end

		if (cmd.div_init) begin
			dg_q   <= g_full;
			quo_q  <= cmd.div_den ? den_q : num_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			if (d_ge) begin
				rem_q <= d_trial[PW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= d_shift[PW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b0};
			end
			dcnt_q <= dcnt_q + CW'(1);
		end

		if (cmd.out_load) begin
			priority if (err_q) begin
				res_num <= '0;
				res_den <= '0;
				status  <= rau_pkg::ST_ZDEN;
				is_zero <= 1'b0;
				is_one  <= 1'b0;
			end else if (ovf) begin
				res_num <= '0;
				res_den <= '0;
				status  <= rau_pkg::ST_OVF;
				is_zero <= 1'b0;
				is_one  <= 1'b0;
			end else begin
				res_num <= 32'(num_sw);
				res_den <= 31'(den_q[W-2:0]);
				status  <= rau_pkg::ST_OK;
				is_zero <= (num_q == '0);
				is_one  <= !neg_q && (num_q == PW'(1)) && (den_q == PW'(1));
			end
		end
	end

endmodule

// ----- src/rational_arith_unit_top.sv -----
// sequence: load, multiply steps T1, T2 and T3, combine, binary gcd, then two restoring
// divisions (numerator, then denominator) and the output load; an error skips to the output load
// one request at a time: in_ready is high only while idle, and the core stays busy
// through the gcd loop and both bit-serial divisions before it takes the next request
// the result register frees the core, so a new request is taken while one waits
// reset clears the sequencer and the output valid flag; datapath registers are not reset
module rational_arith_unit_top #(
	parameter int unsigned WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] res_num,
	output logic [30:0]        res_den,
	output logic [1:0]         status,
	output logic               is_zero,
	output logic               is_one
);

	rau_pkg::rau_cmd_t  cmd;
	rau_pkg::rau_stat_t stat;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rau_dp #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk      (clk),
		.cmd      (cmd),
		.stat     (stat),
		.req_type (req_type),
		.a_num    (a_num),
		.a_den    (a_den),
		.b_num    (b_num),
		.b_den    (b_den),
		.res_num  (res_num),
		.res_den  (res_den),
		.status   (status),
		.is_zero  (is_zero),
		.is_one   (is_one)
	);

endmodule

// ----- bench/tb_rational_arith_unit_top.sv -----
// self-checking bench for rational_arith_unit_top: fraction add/sub/mul/div in lowest terms
// depends on rau_pkg and rational_arith_unit_top; scoreboard class holds the fraction predictor
module tb_rational_arith_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned WB          = rau_pkg::WORD_BITS_DEF;
	localparam int          N_RANDOM    = 500;
	localparam int          HOLD_CYC    = 4000;
	localparam int          END_WAIT    = 16 * WB;
	localparam int          CYCLE_LIMIT = 1_200_000;
	localparam logic [31:0] MAXP        = 32'h7fff_ffff;
	localparam logic [31:0] MINN        = 32'h8000_0000;

	typedef struct packed {
		logic        neg;
		logic [63:0] mag;
	} sm_val_t;

	typedef struct packed {
		logic signed [31:0] num;
		logic [30:0]        den;
		logic [1:0]         st;
		logic               zero;
		logic               one;
	} frac_res_t;

	class rau_scoreboard;
		frac_res_t expected_q[$];
		int        n_errors;
		int        n_accepted;
		int        n_results;

		function new();
			n_errors   = 0;
			n_accepted = 0;
			n_results  = 0;
		endfunction

		function sm_val_t to_sm(logic [31:0] raw);
			logic [63:0] mask;
			logic [63:0] v;
			sm_val_t     r;
			mask = (64'd1 << WB) - 64'd1;
			v    = {32'd0, raw} & mask;
			r.neg = v[WB-1];
			r.mag = r.neg ? ((~v) + 64'd1) & mask : v;
			return r;
		endfunction

		function sm_val_t sm_mul(sm_val_t x, sm_val_t y);
			sm_val_t r;
			r.mag = x.mag * y.mag;
			r.neg = (r.mag != 0) && (x.neg != y.neg);
			return r;
		endfunction

		function sm_val_t sm_add(sm_val_t x, sm_val_t y);
			sm_val_t r;
			if (x.neg == y.neg) begin
				r.mag = x.mag + y.mag;
				r.neg = x.neg;
			end else if (x.mag >= y.mag) begin
				r.mag = x.mag - y.mag;
				r.neg = x.neg;
			end else begin
				r.mag = y.mag - x.mag;
				r.neg = y.neg;
			end
			if (r.mag == 0)
				r.neg = 1'b0;
			return r;
		endfunction

		function logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
			logic [63:0] t;
			while (y != 0) begin
				t = x % y;
				x = y;
				y = t;
			end
			return x;
		endfunction

		function frac_res_t reduce_frac(logic [1:0] op, logic [31:0] an_r, logic [31:0] ad_r,
				logic [31:0] bn_r, logic [31:0] bd_r);
			sm_val_t     an, ad, bn, bd, t2, nm, dn;
			logic [63:0] g, lim, sv;
			logic        neg;
			frac_res_t   r;
			r  = '0;
			an = to_sm(an_r);
			ad = to_sm(ad_r);
			bn = to_sm(bn_r);
			bd = to_sm(bd_r);
			if (ad.mag == 0 || bd.mag == 0 || (op == rau_pkg::OP_DIV && bn.mag == 0)) begin
				r.st = rau_pkg::ST_ZDEN;
				return r;
			end
			case (op)
				rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
					t2 = sm_mul(ad, bn);
					if (op == rau_pkg::OP_SUB && t2.mag != 0)
						t2.neg = ~t2.neg;
					nm = sm_add(sm_mul(an, bd), t2);
					dn = sm_mul(ad, bd);
				end
				rau_pkg::OP_MUL: begin
					nm = sm_mul(an, bn);
					dn = sm_mul(ad, bd);
				end
				default: begin
					nm = sm_mul(an, bd);
					dn = sm_mul(ad, bn);
				end
			endcase
			neg = (nm.mag != 0) && (nm.neg != dn.neg);
			g = euclid_gcd(dn.mag, nm.mag);
			nm.mag = nm.mag / g;
			dn.mag = dn.mag / g;
			lim = 64'd1 << (WB - 1);
			// negative side may reach the full power of two
			if (dn.mag > lim - 64'd1 || nm.mag > (neg ? lim : lim - 64'd1)) begin
				r.st = rau_pkg::ST_OVF;
				return r;
			end
			sv     = neg ? (64'd0 - nm.mag) : nm.mag;
			r.num  = sv[31:0];
			r.den  = dn.mag[30:0];
			r.st   = rau_pkg::ST_OK;
			r.zero = (nm.mag == 0);
			r.one  = !neg && nm.mag == 1 && dn.mag == 1;
			return r;
		endfunction

		function void note_req(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
				logic [31:0] bn, logic [31:0] bd);
			expected_q.push_back(reduce_frac(op, an, ad, bn, bd));
			n_accepted++;
		endfunction

		task report(string msg);
			$display("[%0t] error: %s", $time, msg);
			n_errors++;
		endtask

		task check_res(logic signed [31:0] num, logic [30:0] den, logic [1:0] st,
				logic z, logic o);
			frac_res_t e;
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d with no request pending: %0d/%0d st=%0d",
					n_results, num, den, st));
				return;
			end
			e = expected_q.pop_front();
			if (num !== e.num || den !== e.den || st !== e.st || z !== e.zero || o !== e.one)
				report($sformatf({"result %0d got %0d/%0d st=%0d z=%0b o=%0b, ",
					"want %0d/%0d st=%0d z=%0b o=%0b"},
					n_results, num, den, st, z, o, e.num, e.den, e.st, e.zero, e.one));
		endtask
	endclass

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         req_type  = rau_pkg::OP_ADD;
	logic signed [31:0] a_num     = '0;
	logic signed [31:0] a_den     = '0;
	logic signed [31:0] b_num     = '0;
	logic signed [31:0] b_den     = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] res_num;
	logic [30:0]        res_den;
	logic [1:0]         status;
	logic               is_zero;
	logic               is_one;

	rau_scoreboard sb = new();
	int            cycle_cnt;

	rational_arith_unit_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_num   (res_num),
		.res_den   (res_den),
		.status    (status),
		.is_zero   (is_zero),
		.is_one    (is_one)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_res(res_num, res_den, status, is_zero, is_one);
	end

	// valid stays high across back-to-back requests; the caller lowers it for a gap
	task automatic send_req(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd);
		in_valid <= 1'b1;
		req_type <= op;
		a_num    <= an;
		a_den    <= ad;
		b_num    <= bn;
		b_den    <= bd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_req(op, an, ad, bn, bd);
	endtask

	task automatic idle_cycles(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		logic [31:0] r;
		logic [31:0] v;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = 32'($urandom_range(0, 40)) - 32'd20;
			4, 5:       v = {{16{r[15]}}, r[15:0]};
			6, 7:       v = r;
			8: begin
				case ($urandom_range(0, 6))
					0:       v = 32'd0;
					1:       v = 32'd1;
					2:       v = 32'hffff_ffff;
					3:       v = MAXP;
					4:       v = MINN;
					5:       v = MINN + 32'd1;
					default: v = MAXP - 32'd1;
				endcase
			end
			default: begin
				// shared small factors so the gcd has work to do
				v = 32'($urandom_range(1, 200)) * 32'd36;
				if (r[0])
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin : watchdog
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : result_sink
		int mode;
		int left;
		int hold;
		bit held;
		mode = 0;
		left = 0;
		held = 0;
		forever begin
			@(posedge clk);
			// one long hold-off so the core fills and in_ready stays low
			if (!held && sb.n_accepted >= 150) begin
				held = 1;
				out_ready <= 1'b0;
				for (hold = 0; hold < HOLD_CYC; hold++)
					@(posedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(50, 400);
			end
			left--;
			case (mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin : stimulus
		int  sent;
		int  burst;
		int  i;
		bit  drained;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: signs, zero denominators, extremes, cancellation, unit results
		send_req(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		send_req(rau_pkg::OP_SUB, 32'd2, 32'd4, 32'd1, 32'd2);
		send_req(rau_pkg::OP_MUL, 32'd2, 32'd3, 32'd3, 32'd2);
		send_req(rau_pkg::OP_DIV, -32'd1, 32'd2, 32'd1, 32'd4);
		send_req(rau_pkg::OP_ADD, 32'd1, -32'd2, 32'd0, 32'd5);
		send_req(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		send_req(rau_pkg::OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
		send_req(rau_pkg::OP_SUB, 32'd0, 32'd0, 32'd0, 32'd0);
		send_req(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd7);
		send_req(rau_pkg::OP_DIV, 32'd0, -32'd5, 32'd3, 32'd7);
		send_req(rau_pkg::OP_MUL, MINN, 32'd1, 32'd1, 32'd1);
		send_req(rau_pkg::OP_MUL, MINN, 32'd1, -32'd1, 32'd1);
		send_req(rau_pkg::OP_ADD, MAXP, 32'd1, 32'd1, 32'd1);
		send_req(rau_pkg::OP_MUL, 32'd1, MINN, 32'd1, 32'd1);
		send_req(rau_pkg::OP_MUL, MAXP, 32'd1, MAXP, 32'd1);
		send_req(rau_pkg::OP_DIV, MINN, MINN, MINN, MINN);
		send_req(rau_pkg::OP_ADD, 32'd1, 32'd3, 32'd2, 32'd3);
		send_req(rau_pkg::OP_SUB, -32'd1, -32'd1, -32'd1, -32'd1);
		send_req(rau_pkg::OP_SUB, MINN, 32'd1, MAXP, 32'd1);
		send_req(rau_pkg::OP_ADD, MAXP, 32'd2, MAXP, 32'd2);
		send_req(rau_pkg::OP_DIV, -32'd1, 32'd1, MINN, 32'd1);
		send_req(rau_pkg::OP_ADD, MINN, 32'd1, 32'd0, 32'd1);
		send_req(rau_pkg::OP_SUB, 32'd0, 32'd1, MINN, 32'd1);
		send_req(rau_pkg::OP_MUL, 32'd6, -32'd4, -32'd10, 32'd9);

		// sender pause until every result is back
		drain();

		sent    = 0;
		drained = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 12);
			for (i = 0; i < burst && sent < N_RANDOM; i++) begin
				send_req(2'($urandom_range(0, 3)), pick_operand(), pick_operand(),
					pick_operand(), pick_operand());
				sent++;
			end
			case ($urandom_range(0, 7))
				0:       idle_cycles($urandom_range(100, 500));
				1, 2:    idle_cycles($urandom_range(10, 80));
				default: idle_cycles($urandom_range(0, 8));
			endcase
			if (!drained && sent >= 300) begin
				drained = 1;
				drain();
			end
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (sb.n_errors == 0 && sb.expected_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
